/* rtl/ar_interp_pkg.sv */
`default_nettype none

package ar_interp_pkg;

  localparam int MAX_GAP         = 64;
  localparam int TAG_WIDTH       = 16;
  localparam int ANGLE_FRAC_BITS = 6;

  localparam int ANG_W     = 16;
  localparam int TIME_W    = 32;
  localparam int TAG_FLD_W = 16;
  localparam int TAG_KEEP  = (TAG_WIDTH < TAG_FLD_W) ? TAG_WIDTH : TAG_FLD_W;

  localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;

  // Angle width after a full turn has been added, with room for a signed difference.
  localparam int ANGX_W = $clog2(FULL_TURN + 65536) + 1;
  // Gap width: holds MAX_GAP itself.
  localparam int D_W    = $clog2(MAX_GAP + 1);
  // Numerator width of the interpolation sum.
  localparam int ACC_W  = ANGX_W + D_W + 1;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/ar_interp_div.sv */
`default_nettype none

module ar_interp_div (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire  [ar_interp_pkg::ACC_W-1:0]   dividend,
  input  wire  [ar_interp_pkg::D_W-1:0]     divisor,
  output logic [ar_interp_pkg::ACC_W-1:0]   quotient,
  output ar_interp_pkg::div_stat_t          stat
);

  localparam int AW = ar_interp_pkg::ACC_W;
  localparam int DW = ar_interp_pkg::D_W;
  localparam int CW = ar_interp_pkg::CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [DW:0]   trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[AW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(AW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DW'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[AW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[AW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* rtl/angle_resampler_interpolate.sv */
`default_nettype none

// Channel  Direction  Signals                     Contents
// in       slave      in_tvalid/tready/tdata      one timestamped angle sample
// out      master     out_tvalid/tready/tdata/    one resampled angle, flags in tuser,
//                     tuser/tlast                 tlast on the final result of a sample
//
// A sample that gives no result leaves the input ready; one that gives only the pass-through or gap
// error result holds the input until the output register has been emptied. Each interpolated
// result comes from the shared restoring divider, which produces one quotient bit per cycle; the
// first result of a sample is preceded by the setup and multiply states.
// A sample is taken only while the sequencer is idle and the output register is empty.
// A stalled output holds the sequencer; reset is synchronous and clears the stored sample.

module angle_resampler_interpolate (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // sample_angle[15:0], sample_time[47:16], sample_tag[63:48]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // out_angle[15:0], out_time[47:16], out_tag[63:48]
  output logic [1:0]  out_tuser,  // is_original[0], status[1]
  output logic        out_tlast
);

  localparam int AW = ar_interp_pkg::ACC_W;
  localparam int XW = ar_interp_pkg::ANGX_W;
  localparam int DW = ar_interp_pkg::D_W;
  localparam int TW = ar_interp_pkg::TIME_W;
  localparam int GW = ar_interp_pkg::TAG_KEEP;
  localparam int NW = ar_interp_pkg::ANG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_FINAL = 3'd7;

  logic [2:0] state_r, state_nxt;

  logic                 have_prev_r, have_prev_nxt;
  logic signed [NW-1:0] prev_a_r, prev_a_nxt;
  logic [TW-1:0]        prev_t_r, prev_t_nxt;
  logic [GW-1:0]        prev_g_r, prev_g_nxt;

  logic signed [NW-1:0] cur_a_r, cur_a_nxt;
  logic [TW-1:0]        cur_t_r, cur_t_nxt;
  logic [GW-1:0]        cur_g_r, cur_g_nxt;
  logic [DW-1:0]        d_r, d_nxt;
  logic [DW-1:0]        i_r, i_nxt;

  logic signed [XW-1:0] lo_r, lo_nxt;
  logic signed [XW-1:0] hi_r, hi_nxt;
  logic signed [AW-1:0] step_r, step_nxt;
  logic signed [AW-1:0] num_r, num_nxt;
  logic signed [AW-1:0] val_r, val_nxt;
  logic                 neg_r, neg_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [63:0]  out_data_r, out_data_nxt;
  logic [1:0]   out_user_r, out_user_nxt;
  logic         out_last_r, out_last_nxt;

  logic signed [NW-1:0] s_a;
  logic [TW-1:0]        s_t;
  logic [GW-1:0]        s_g;
  logic [TW:0]          tdiff;
  logic                 in_acc;

  logic signed [XW-1:0] pa_e, sa_e, adiff, aabs;
  logic signed [AW-1:0] lo_w, d_w, val_wr;
  logic [AW-1:0]        div_q;
  logic                 div_start;
  ar_interp_pkg::div_stat_t div_st;

  assign s_a    = signed'(in_tdata[15:0]);
  assign s_t    = in_tdata[47:16];
  assign s_g    = in_tdata[48 +: GW];
  assign tdiff  = {1'b0, s_t} - {1'b0, prev_t_r};
  assign in_acc = in_tvalid && in_tready;

  assign pa_e  = XW'(prev_a_r);
  assign sa_e  = XW'(cur_a_r);
  assign adiff = sa_e - pa_e;
  assign aabs  = adiff[XW-1] ? -adiff : adiff;
  assign lo_w  = AW'(lo_r);
  assign d_w   = signed'(AW'(d_r));

  assign val_wr = (val_r >= AW'(ar_interp_pkg::FULL_TURN)) ?
                  (val_r - AW'(ar_interp_pkg::FULL_TURN)) : val_r;

  assign div_start = (state_r == S_START);

  ar_interp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r[AW-1] ? AW'(-num_r) : AW'(num_r)),
    .divisor  (d_r),
    .quotient (div_q),
    .stat     (div_st)
  );

  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    prev_a_nxt    = prev_a_r;
    prev_t_nxt    = prev_t_r;
    prev_g_nxt    = prev_g_r;
    cur_a_nxt     = cur_a_r;
    cur_t_nxt     = cur_t_r;
    cur_g_nxt     = cur_g_r;
    d_nxt         = d_r;
    i_nxt         = i_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    step_nxt      = step_r;
    num_nxt       = num_r;
    val_nxt       = val_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          have_prev_nxt = 1'b1;
          prev_a_nxt    = s_a;
          prev_t_nxt    = s_t;
          prev_g_nxt    = s_g;
          if (have_prev_r && !tdiff[TW] && (tdiff[TW-1:0] != '0)) begin
            if (tdiff[TW-1:0] > TW'(ar_interp_pkg::MAX_GAP)) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = {16'(s_g), s_t, s_a};
              out_user_nxt  = 2'b11;
              out_last_nxt  = 1'b1;
            end else if (tdiff[TW-1:0] == TW'(1)) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = {16'(s_g), s_t, s_a};
              out_user_nxt  = 2'b01;
              out_last_nxt  = 1'b1;
            end else begin
              have_prev_nxt = have_prev_r;
              prev_a_nxt    = prev_a_r;
              prev_t_nxt    = prev_t_r;
              prev_g_nxt    = prev_g_r;
              cur_a_nxt     = s_a;
              cur_t_nxt     = s_t;
              cur_g_nxt     = s_g;
              d_nxt         = tdiff[DW-1:0];
              i_nxt         = DW'(1);
              state_nxt     = S_SETUP;
            end
          end
        end
      end
      S_SETUP: begin
        lo_nxt = pa_e;
        hi_nxt = sa_e;
        if (aabs > XW'(ar_interp_pkg::HALF_TURN)) begin
          if (pa_e > sa_e) begin
            hi_nxt = sa_e + XW'(ar_interp_pkg::FULL_TURN);
          end else begin
            lo_nxt = pa_e + XW'(ar_interp_pkg::FULL_TURN);
          end
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        step_nxt  = AW'(hi_r) - lo_w;
        num_nxt   = lo_w * d_w + (AW'(hi_r) - lo_w);
        state_nxt = S_START;
      end
      S_START: begin
        neg_nxt   = num_r[AW-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        val_nxt   = neg_r ? -signed'(div_q) : signed'(div_q);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {16'(prev_g_r), prev_t_r + TW'(i_r), val_wr[NW-1:0]};
          out_user_nxt  = 2'b00;
          out_last_nxt  = 1'b0;
          i_nxt         = i_r + DW'(1);
          num_nxt       = num_r + step_r;
          state_nxt     = ((i_r + DW'(1)) == d_r) ? S_FINAL : S_START;
        end
      end
      S_FINAL: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {16'(cur_g_r), cur_t_r, cur_a_r};
          out_user_nxt  = 2'b01;
          out_last_nxt  = 1'b1;
          have_prev_nxt = 1'b1;
          prev_a_nxt    = cur_a_r;
          prev_t_nxt    = cur_t_r;
          prev_g_nxt    = cur_g_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      prev_a_r    <= '0;
      prev_t_r    <= '0;
      prev_g_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      prev_a_r    <= prev_a_nxt;
      prev_t_r    <= prev_t_nxt;
      prev_g_r    <= prev_g_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_a_r    <= cur_a_nxt;
    cur_t_r    <= cur_t_nxt;
    cur_g_r    <= cur_g_nxt;
    d_r        <= d_nxt;
    i_r        <= i_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    step_r     <= step_nxt;
    num_r      <= num_nxt;
    val_r      <= val_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tuser[0] && out_tlast))
    else $error("gap error transaction is not a final pass-through");

  a_last_is_orig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser[0]))
    else $error("tlast does not match the pass-through flag");

  a_interp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (state_r != S_IDLE))
    else $error("interpolated transaction pending while the sequencer is idle");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_st.busy || div_st.done) |-> (state_r == S_DIV))
    else $error("divider active outside the divide state");
`endif

endmodule

`default_nettype wire
